// ===== rtl/bpft_pkg.sv =====
// Shared types and codes for the buffer pool frame table.
// Used by bpft_front, bpft_back and the top module; depends on nothing.
`default_nettype none
package bpft_pkg;

    localparam int FRAMES_DEF   = 16;
    localparam int PIN_BITS_DEF = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int PAGE_W       = 31;

    localparam logic [4:0] FRAMES_IN_USE_RESET = 5'd16;

    localparam logic [2:0] OP_PIN   = 3'd0;
    localparam logic [2:0] OP_UNPIN = 3'd1;
    localparam logic [2:0] OP_DIRTY = 3'd2;
    localparam logic [2:0] OP_FORCE = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_ALL_PIN = 2'd2;

    typedef enum logic [2:0] {
        K_PIN   = 3'd0,
        K_UNPIN = 3'd1,
        K_DIRTY = 3'd2,
        K_FORCE = 3'd3,
        K_FLUSH = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [PAGE_W-1:0]  page;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         frame;
        logic               hit;
        logic               wb;
        logic [PAGE_W-1:0]  wpage;
        logic               rf;
        logic [PAGE_W-1:0]  rpage;
        logic [15:0]        pins;
        logic               dirty;
        logic [31:0]        rtot;
        logic [31:0]        wtot;
        logic               last;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/bpft_fifo.sv =====
// Small register queue carrying a flat item of WIDTH bits.
// Used between the front and back parts and at the result side.
`default_nettype none
module bpft_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  is_full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  is_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign is_full  = (32'(cnt_reg) == DEPTH);
    assign is_empty = (cnt_reg == '0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && !is_empty;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wp_next = (32'(wp_reg) == DEPTH - 1) ? '0 : wp_reg + 1'b1;
        end
        if (do_rd)
        begin
            rp_next = (32'(rp_reg) == DEPTH - 1) ? '0 : rp_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bpft_front.sv =====
// Front part: accepts requests, classifies the operation, queues commands.
// Depends on bpft_pkg and bpft_fifo.
`default_nettype none
module bpft_front
    import bpft_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [2:0]        operation,
    input  wire logic [PAGE_W-1:0] page_number,
    input  wire logic              cmd_pop,
    output cmd_t                   cmd,
    output logic                   cmd_empty
);
    cmd_t   cin;
    logic   known;
    logic [$bits(cmd_t)-1:0] cout;

    always_comb
    begin
        cin.page = page_number;
        cin.kind = K_PIN;
        known    = 1'b1;
        case (operation)
            OP_PIN:   cin.kind = K_PIN;
            OP_UNPIN: cin.kind = K_UNPIN;
            OP_DIRTY: cin.kind = K_DIRTY;
            OP_FORCE: cin.kind = K_FORCE;
            OP_FLUSH: cin.kind = K_FLUSH;
            default:  known    = 1'b0;   // drop unknown operations
        endcase
    end

    bpft_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push && known),
        .wr_data  (cin),
        .is_full  (full),
        .rd_en    (cmd_pop),
        .rd_data  (cout),
        .is_empty (cmd_empty)
    );

    assign cmd = cmd_t'(cout);
endmodule
`default_nettype wire

// ===== rtl/bpft_back.sv =====
// Back part: holds the frame table and carries out one command at a time.
// Depends on bpft_pkg; pushes results into the result queue.
`default_nettype none
module bpft_back
    import bpft_pkg::*;
#(
    parameter int FRAMES   = FRAMES_DEF,
    parameter int PIN_BITS = PIN_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [4:0] fiu,
    input  wire cmd_t       cmd,
    input  wire logic       cmd_empty,
    output logic            cmd_pop,
    input  wire logic       res_full,
    output logic            res_push,
    output res_t            res
);
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW = $clog2(FRAMES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_FLUSH  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [NW-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]       vp_reg, vp_next;
    logic [31:0]         rd_reg, rd_next;
    logic [31:0]         wr_reg, wr_next;

    logic [PAGE_W-1:0]   fpage_reg  [FRAMES];
    logic [PAGE_W-1:0]   fpage_next [FRAMES];
    logic [FRAMES-1:0]   valid_reg, valid_next;
    logic [FRAMES-1:0]   dirty_reg, dirty_next;
    logic [PIN_BITS-1:0] pins_reg  [FRAMES];
    logic [PIN_BITS-1:0] pins_next [FRAMES];

    logic [FRAMES-1:0]   match, elig;
    logic                hit, above, free, cur_last;
    logic [IW-1:0]       hidx, cur_wrap;
    logic [31:0]         fiu_ext;
    logic [NW-1:0]       n_cfg;
    logic                wb_page_write;

    always_comb
    begin
        fiu_ext = 32'(fiu);
        if (fiu_ext == 0)
        begin
            n_cfg = NW'(1);
        end
        else if (fiu_ext > FRAMES)
        begin
            n_cfg = NW'(FRAMES);
        end
        else
        begin
            n_cfg = NW'(fiu_ext);
        end
    end

    // Parallel tag compare; lowest matching frame wins.
    always_comb
    begin
        hit  = 1'b0;
        hidx = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            match[i] = valid_reg[i] && (fpage_reg[i] == page_reg) && (i < 32'(n_reg));
            elig[i]  = valid_reg[i] && dirty_reg[i] && (pins_reg[i] == '0)
                       && (i < 32'(n_reg));
        end
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit  = 1'b1;
                hidx = IW'(i);
            end
        end
        above = 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (elig[i] && (i > 32'(cur_reg)))
            begin
                above = 1'b1;
            end
        end
        cur_last = (32'(cur_reg) + 1 == 32'(n_reg));
        cur_wrap = cur_last ? '0 : cur_reg + 1'b1;
        free     = !valid_reg[cur_reg] || (pins_reg[cur_reg] == '0);
    end

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        page_next     = page_reg;
        n_next        = n_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        vp_next       = vp_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        fpage_next    = fpage_reg;
        valid_next    = valid_reg;
        dirty_next    = dirty_reg;
        pins_next     = pins_reg;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        wb_page_write = 1'b0;
        res           = '0;
        res.last      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    kind_next  = cmd.kind;
                    page_next  = cmd.page;
                    n_next     = n_cfg;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (kind_reg == K_FLUSH)
                begin
                    cur_next   = '0;
                    state_next = S_FLUSH;
                end
                else if (kind_reg == K_PIN && !hit)
                begin
                    cur_next   = (32'(vp_reg) < 32'(n_reg)) ? vp_reg : '0;
                    cnt_next   = '0;
                    state_next = S_SEARCH;
                end
                else if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                    if (!hit)
                    begin
                        res.status = ST_MISSING;
                    end
                    else
                    begin
                        res.frame = 4'(hidx);
                        res.hit   = 1'b1;
                        case (kind_reg)
                            K_PIN:
                            begin
                                if (pins_reg[hidx] != '1)
                                begin
                                    pins_next[hidx] = pins_reg[hidx] + 1'b1;
                                end
                            end
                            K_UNPIN:
                            begin
                                if (pins_reg[hidx] != '0)
                                begin
                                    pins_next[hidx] = pins_reg[hidx] - 1'b1;
                                end
                            end
                            K_DIRTY:
                            begin
                                dirty_next[hidx] = 1'b1;
                            end
                            K_FORCE:
                            begin
                                dirty_next[hidx] = 1'b0;
                                wr_next          = wr_reg + 1'b1;
                                res.wb           = 1'b1;
                                res.wpage        = page_reg;
                            end
                            default:
                            begin
                                res.hit = 1'b1;
                            end
                        endcase
                        res.pins  = 16'(pins_next[hidx]);
                        res.dirty = dirty_next[hidx];
                    end
                end
            end
            S_SEARCH:
            begin
                if (free)
                begin
                    if (!res_full)
                    begin
                        wb_page_write = valid_reg[cur_reg] && dirty_reg[cur_reg];
                        if (wb_page_write)
                        begin
                            wr_next   = wr_reg + 1'b1;
                            res.wb    = 1'b1;
                            res.wpage = fpage_reg[cur_reg];
                        end
                        rd_next             = rd_reg + 1'b1;
                        fpage_next[cur_reg] = page_reg;
                        valid_next[cur_reg] = 1'b1;
                        dirty_next[cur_reg] = 1'b0;
                        pins_next[cur_reg]  = PIN_BITS'(1);
                        vp_next             = cur_wrap;
                        res.frame           = 4'(cur_reg);
                        res.rf              = 1'b1;
                        res.rpage           = page_reg;
                        res.pins            = 16'(1);
                        res_push            = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
                else if (32'(cnt_reg) + 1 == 32'(n_reg))
                begin
                    if (!res_full)
                    begin
                        res.status = ST_ALL_PIN;
                        res_push   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cur_next = cur_wrap;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (!elig[cur_reg] || !res_full)
                begin
                    if (elig[cur_reg])
                    begin
                        dirty_next[cur_reg] = 1'b0;
                        wr_next    = wr_reg + 1'b1;
                        res.frame  = 4'(cur_reg);
                        res.hit    = 1'b1;
                        res.wb     = 1'b1;
                        res.wpage  = fpage_reg[cur_reg];
                        res.pins   = '0;
                        res.last   = !above;
                        res_push   = 1'b1;
                    end
                    if (cur_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        res.rtot = rd_next;
        res.wtot = wr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vp_reg    <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                pins_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            vp_reg    <= vp_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            pins_reg  <= pins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        page_reg  <= page_next;
        n_reg     <= n_next;
        cur_reg   <= cur_next;
        cnt_reg   <= cnt_next;
        fpage_reg <= fpage_next;
    end
endmodule
`default_nettype wire

// ===== rtl/buffer_pool_frame_table.sv =====
// Buffer pool frame table with FIFO replacement. Requests enter a two-entry
// command queue and are carried out one at a time by the frame table engine;
// results leave through a two-entry result queue. Pin hit, unpin, mark dirty
// and force are popped in the idle state and carried out in the lookup state.
// A pin miss walks the frames in use from the victim pointer, and flush walks
// every frame in use, one frame per cycle while the result queue has room.
// Depends on bpft_pkg, bpft_front, bpft_back and bpft_fifo.
`default_nettype none
module buffer_pool_frame_table
    import bpft_pkg::*;
#(
    parameter int FRAMES   = FRAMES_DEF,
    parameter int PIN_BITS = PIN_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [2:0]        operation,
    input  wire logic [PAGE_W-1:0] page_number,
    output logic                   empty,
    input  wire logic              pop,
    output logic [1:0]             status,
    output logic [3:0]             frame_index,
    output logic                   hit,
    output logic                   write_back,
    output logic [PAGE_W-1:0]      write_page,
    output logic                   read_fetch,
    output logic [PAGE_W-1:0]      read_page,
    output logic [15:0]            pin_count,
    output logic                   dirty,
    output logic [31:0]            read_total,
    output logic [31:0]            write_total,
    output logic                   last,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [4:0]        frames_in_use
);
    logic [4:0] fiu_reg;
    cmd_t       cmd;
    logic       cmd_empty, cmd_pop;
    logic       res_full, res_push;
    res_t       res_in, res_out;
    logic [$bits(res_t)-1:0] res_flat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg <= FRAMES_IN_USE_RESET;
        end
        else if (cfg_valid)
        begin
            fiu_reg <= frames_in_use;
        end
    end

    bpft_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .page_number (page_number),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .cmd_empty   (cmd_empty)
    );

    bpft_back #(
        .FRAMES   (FRAMES),
        .PIN_BITS (PIN_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fiu       (fiu_reg),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    bpft_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_push),
        .wr_data  (res_in),
        .is_full  (res_full),
        .rd_en    (pop),
        .rd_data  (res_flat),
        .is_empty (empty)
    );

    assign res_out     = res_t'(res_flat);
    assign status      = res_out.status;
    assign frame_index = res_out.frame;
    assign hit         = res_out.hit;
    assign write_back  = res_out.wb;
    assign write_page  = res_out.wpage;
    assign read_fetch  = res_out.rf;
    assign read_page   = res_out.rpage;
    assign pin_count   = res_out.pins;
    assign dirty       = res_out.dirty;
    assign read_total  = res_out.rtot;
    assign write_total = res_out.wtot;
    assign last        = res_out.last;
endmodule
`default_nettype wire
